FILE: src/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define HTVP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");

// Clocked assertion that also runs during reset.
`define HTVP_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: src/htvp_pkg.sv
// Package for the header TLV version parser: register codes, reset values,
// scan phase encoding and the scan state record. No dependencies.
`default_nettype none

package htvp_pkg;

    localparam int MAX_HDR_DEFAULT = 4096;
    localparam int MIN_HDR_LEN     = 8;
    localparam int MAGIC_BYTES     = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDING_BYTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_TAG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN   = 3'd4;

    localparam logic [31:0] RST_MAGIC_WORD   = 32'd1179406167;
    localparam logic [7:0]  RST_PADDING_BYTE = 8'hFF;
    localparam logic [15:0] RST_VERSION_TAG  = 16'd1;
    localparam logic [12:0] RST_START_OFFSET = 13'd8;
    localparam logic [12:0] RST_HEADER_LEN   = 13'd256;

    localparam logic [15:0] TAG_NONE    = 16'h0000;
    localparam logic [15:0] TAG_END     = 16'hFFFF;
    localparam logic [15:0] VERSION_LEN = 16'd4;
    localparam int          RECORD_HDR  = 4;

    typedef enum logic [6:0] {
        PH_WAIT   = 7'b0000001,
        PH_SCAN   = 7'b0000010,
        PH_TYPEHI = 7'b0000100,
        PH_LENLO  = 7'b0001000,
        PH_LENHI  = 7'b0010000,
        PH_VALUE  = 7'b0100000,
        PH_SKIP   = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] tag;
        logic [15:0] len;
        logic [15:0] skip;
        logic [31:0] ver;
        logic        stop;
        logic        found;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        phase: PH_WAIT,
        tag:   16'h0000,
        len:   16'h0000,
        skip:  16'h0000,
        ver:   32'h0000_0000,
        stop:  1'b0,
        found: 1'b0
    };

endpackage

`default_nettype wire

FILE: src/htvp_in_if.sv
// Input channel: one header byte per request.
// No dependencies.
`default_nettype none

interface htvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;

    modport source (output valid, output header_byte, input ready);
    modport sink   (input valid, input header_byte, output ready);
endinterface

`default_nettype wire

FILE: src/htvp_out_if.sv
// Result channel: version, found flag and magic flag, one request per header.
// No dependencies.
`default_nettype none

interface htvp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] blob_version;
    logic        version_found;
    logic        magic_ok;

    modport source (output valid, output blob_version, output version_found,
                    output magic_ok, input ready);
    modport sink   (input valid, input blob_version, input version_found,
                    input magic_ok, output ready);
endinterface

`default_nettype wire

FILE: src/header_tlv_version_parser.sv
// Header TLV version parser: one header byte accepted per cycle, no stall
// unless the result register is full and not taken. The result is registered
// in the output register in the cycle after the last header byte is accepted.
// Throughput: one byte per cycle unless stalled, set by the single state register update.
// Reset (i_rst_n low, synchronous) clears scan state, empties the result
// register and loads the registers with their defaults.
// Depends on htvp_pkg, htvp_in_if, htvp_out_if, htvp_scan.
`default_nettype none

module header_tlv_version_parser
    import htvp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HDR_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    htvp_in_if.sink                    i_in,
    htvp_out_if.source                 o_out
);

    localparam int PW = $clog2(MAX_HEADER_BYTES);
    localparam int LW = $clog2(MAX_HEADER_BYTES + 1);
    localparam int CW = ((LW > 16) ? LW : 16) + 2;

    logic [31:0]   r_cfg_magic;
    logic [7:0]    r_cfg_pad;
    logic [15:0]   r_cfg_vtag;
    logic [12:0]   r_cfg_start;
    logic [12:0]   r_cfg_hlen;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [31:0]   r_magic;
    logic [31:0]   n_magic;
    t_scan         r_st;
    t_scan         n_st;

    logic          r_out_valid;
    logic [31:0]   r_out_version;
    logic          r_out_found;
    logic          r_out_mok;

    logic [CW-1:0] pos_c;
    logic [CW-1:0] hl_c;
    logic [CW-1:0] len_c;
    logic [CW-1:0] rem;
    logic          started;
    logic          last;
    logic          accept;
    logic          mok;

    assign pos_c   = CW'(r_pos);
    assign hl_c    = CW'(r_cfg_hlen);
    assign len_c   = (hl_c < CW'(MIN_HDR_LEN)) ? CW'(MIN_HDR_LEN) :
                     (hl_c > CW'(MAX_HEADER_BYTES)) ? CW'(MAX_HEADER_BYTES) : hl_c;
    assign rem     = (len_c > pos_c) ? len_c - pos_c : '0;
    assign started = pos_c >= CW'(r_cfg_start);
    assign last    = !((pos_c + CW'(1)) < len_c);

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_magic = r_magic;
        if (pos_c < CW'(MAGIC_BYTES)) begin
            n_magic[8*r_pos[1:0] +: 8] = i_in.header_byte;
        end
    end

    assign mok   = n_magic == r_cfg_magic;
    assign n_pos = r_pos + PW'(1);

    htvp_scan #(
        .REM_W (CW)
    ) u_scan (
        .i_st      (r_st),
        .i_byte    (i_in.header_byte),
        .i_odd     (r_pos[0]),
        .i_started (started),
        .i_rem     (rem),
        .i_pad     (r_cfg_pad),
        .i_vtag    (r_cfg_vtag),
        .o_st      (n_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_magic <= RST_MAGIC_WORD;
            r_cfg_pad   <= RST_PADDING_BYTE;
            r_cfg_vtag  <= RST_VERSION_TAG;
            r_cfg_start <= RST_START_OFFSET;
            r_cfg_hlen  <= RST_HEADER_LEN;
            r_pos       <= '0;
            r_magic     <= '0;
            r_st        <= SCAN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAGIC_WORD:   r_cfg_magic <= i_cfg_data;
                    CFG_PADDING_BYTE: r_cfg_pad   <= i_cfg_data[7:0];
                    CFG_VERSION_TAG:  r_cfg_vtag  <= i_cfg_data[15:0];
                    CFG_START_OFFSET: r_cfg_start <= i_cfg_data[12:0];
                    CFG_HEADER_LEN:   r_cfg_hlen  <= i_cfg_data[12:0];
                    default: begin
                    end
                endcase
            end
            if (accept && last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (last) begin
                    r_pos   <= '0;
                    r_magic <= '0;
                    r_st    <= SCAN_RESET;
                end else begin
                    r_pos   <= n_pos;
                    r_magic <= n_magic;
                    r_st    <= n_st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && last) begin
            r_out_version <= (mok && n_st.found) ? n_st.ver : 32'd0;
            r_out_found   <= mok && n_st.found;
            r_out_mok     <= mok;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.blob_version  = r_out_version;
    assign o_out.version_found = r_out_found;
    assign o_out.magic_ok      = r_out_mok;

endmodule

`default_nettype wire

FILE: src/htvp_scan.sv
// Per-byte next-state logic of the TLV record scanner.
// Depends on htvp_pkg.
`default_nettype none

module htvp_scan
    import htvp_pkg::*;
#(
    parameter int REM_W = 18
) (
    input  wire t_scan             i_st,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_odd,
    input  wire logic              i_started,
    input  wire logic [REM_W-1:0]  i_rem,
    input  wire logic [7:0]        i_pad,
    input  wire logic [15:0]       i_vtag,
    output t_scan                  o_st
);

    t_phase      ph;
    logic [15:0] tag_n;
    logic [15:0] len_n;
    logic [15:0] skip_n;
    logic        overrun;

    assign tag_n   = {i_byte, i_st.tag[7:0]};
    assign len_n   = {i_byte, i_st.len[7:0]};
    assign skip_n  = (i_st.phase == PH_VALUE) ? i_st.skip + 16'd1 : i_st.skip - 16'd1;
    assign overrun = (i_rem + REM_W'(RECORD_HDR - 1)) < (REM_W'(len_n) + REM_W'(RECORD_HDR));

    always_comb begin
        o_st = i_st;
        ph   = i_st.phase;
        if (ph == PH_WAIT && i_started) begin
            ph = PH_SCAN;
        end
        if (!i_st.stop) begin
            unique case (ph)
                PH_WAIT: begin
                    o_st.phase = PH_WAIT;
                end
                PH_SCAN: begin
                    o_st.phase = PH_SCAN;
                    if (i_rem < REM_W'(RECORD_HDR)) begin
                        o_st.stop = 1'b1;
                    end else if (!(i_byte == i_pad || i_odd)) begin
                        o_st.tag   = {8'h00, i_byte};
                        o_st.phase = PH_TYPEHI;
                    end
                end
                PH_TYPEHI: begin
                    o_st.tag = tag_n;
                    if (tag_n == TAG_NONE || tag_n == TAG_END) begin
                        o_st.stop = 1'b1;
                    end else begin
                        o_st.phase = PH_LENLO;
                    end
                end
                PH_LENLO: begin
                    o_st.len   = {8'h00, i_byte};
                    o_st.phase = PH_LENHI;
                end
                PH_LENHI: begin
                    o_st.len = len_n;
                    priority if (overrun) begin
                        o_st.stop = 1'b1;
                    end else if (i_st.tag == i_vtag && len_n == VERSION_LEN) begin
                        o_st.skip  = 16'd0;
                        o_st.ver   = 32'd0;
                        o_st.phase = PH_VALUE;
                    end else if (len_n == 16'd0) begin
                        o_st.phase = PH_SCAN;
                    end else begin
                        o_st.skip  = len_n;
                        o_st.phase = PH_SKIP;
                    end
                end
                PH_VALUE: begin
                    o_st.ver[8*i_st.skip[1:0] +: 8] = i_byte;
                    o_st.skip = skip_n;
                    if (skip_n >= 16'(MAGIC_BYTES)) begin
                        o_st.found = 1'b1;
                        o_st.stop  = 1'b1;
                    end
                end
                PH_SKIP: begin
                    o_st.skip = skip_n;
                    if (skip_n == 16'd0) begin
                        o_st.phase = PH_SCAN;
                    end
                end
                default: begin
                    o_st.stop = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/htvp_checker.sv
// Port-level checks for the header TLV version parser, bound to the top.
// Depends on assert_macros.svh and header_tlv_version_parser.
`default_nettype none
`include "assert_macros.svh"

module htvp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_version,
    input wire logic        i_found,
    input wire logic        i_mok
);

    // result register empty means input side can never stall
    `HTVP_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready)

    `HTVP_ASSERT(a_found_needs_magic, i_clk, i_rst_n, (i_out_valid && i_found) |-> i_mok)

    `HTVP_ASSERT(a_version_zero, i_clk, i_rst_n, (i_out_valid && !i_found) |-> (i_version == 32'd0))

    `HTVP_ASSERT(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_version) && $stable(i_found) && $stable(i_mok)))

    `HTVP_ASSERT_NORST(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind header_tlv_version_parser htvp_checker u_htvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_version   (o_out.blob_version),
    .i_found     (o_out.version_found),
    .i_mok       (o_out.magic_ok)
);

`default_nettype wire

FILE: dv/htvp_version_sb_pkg.sv
// Scoreboard for the header TLV version parser: follows the scan of every
// accepted header byte, keeps the predicted results and checks each result.
// Depends on htvp_pkg.
package htvp_version_sb_pkg;
    import htvp_pkg::*;

    typedef struct packed {
        logic [31:0] blob_version;
        logic        version_found;
        logic        magic_ok;
    } t_blob_result;

    class version_scoreboard;
        logic [31:0] magic_word;
        logic [7:0]  padding_byte;
        logic [15:0] version_tag;
        logic [12:0] start_offset;
        logic [12:0] header_len;

        int          byte_pos;
        t_phase      phase;
        logic [31:0] magic_acc;
        logic [15:0] tag_acc;
        logic [15:0] len_acc;
        logic [15:0] skip_cnt;
        logic [31:0] version_acc;
        bit          stopped;
        bit          found;

        t_blob_result predicted_results[$];
        int           errors;

        function new();
            magic_word   = RST_MAGIC_WORD;
            padding_byte = RST_PADDING_BYTE;
            version_tag  = RST_VERSION_TAG;
            start_offset = RST_START_OFFSET;
            header_len   = RST_HEADER_LEN;
            errors       = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            byte_pos    = 0;
            phase       = PH_WAIT;
            magic_acc   = '0;
            tag_acc     = '0;
            len_acc     = '0;
            skip_cnt    = '0;
            version_acc = '0;
            stopped     = 1'b0;
            found       = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAGIC_WORD:   magic_word   = data;
                CFG_PADDING_BYTE: padding_byte = data[7:0];
                CFG_VERSION_TAG:  version_tag  = data[15:0];
                CFG_START_OFFSET: start_offset = data[12:0];
                CFG_HEADER_LEN:   header_len   = data[12:0];
                default: ;
            endcase
        endfunction

        function int header_bytes();
            int n;
            n = header_len;
            if (n < MIN_HDR_LEN) n = MIN_HDR_LEN;
            if (n > MAX_HDR_DEFAULT) n = MAX_HDR_DEFAULT;
            return n;
        endfunction

        function void scan_record_byte(logic [7:0] b, int p, int len);
            int rem;
            rem = (len > p) ? len - p : 0;
            if (phase == PH_WAIT) begin
                if (p < start_offset) return;
                phase = PH_SCAN;
            end
            case (phase)
                PH_SCAN: begin
                    if (rem < RECORD_HDR) begin
                        stopped = 1'b1;
                    end else if (b != padding_byte && p % 2 == 0) begin
                        tag_acc = {8'h00, b};
                        phase   = PH_TYPEHI;
                    end
                end
                PH_TYPEHI: begin
                    tag_acc = {b, tag_acc[7:0]};
                    if (tag_acc == TAG_NONE || tag_acc == TAG_END) stopped = 1'b1;
                    else phase = PH_LENLO;
                end
                PH_LENLO: begin
                    len_acc = {8'h00, b};
                    phase   = PH_LENHI;
                end
                PH_LENHI: begin
                    len_acc = {b, len_acc[7:0]};
                    // rem + 3 is what is left from the record's first byte
                    if (rem + 3 < RECORD_HDR + int'(len_acc)) begin
                        stopped = 1'b1;
                    end else if (tag_acc == version_tag && len_acc == VERSION_LEN) begin
                        skip_cnt    = '0;
                        version_acc = '0;
                        phase       = PH_VALUE;
                    end else if (len_acc == 16'd0) begin
                        phase = PH_SCAN;
                    end else begin
                        skip_cnt = len_acc;
                        phase    = PH_SKIP;
                    end
                end
                PH_VALUE: begin
                    version_acc = version_acc | (32'(b) << (8 * skip_cnt[1:0]));
                    skip_cnt    = skip_cnt + 16'd1;
                    if (skip_cnt >= 16'd4) begin
                        found   = 1'b1;
                        stopped = 1'b1;
                    end
                end
                PH_SKIP: begin
                    skip_cnt = skip_cnt - 16'd1;
                    if (skip_cnt == 16'd0) phase = PH_SCAN;
                end
                default: stopped = 1'b1;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            int           len;
            int           p;
            bit           mok;
            t_blob_result r;
            len = header_bytes();
            p   = byte_pos;
            if (p < MAGIC_BYTES) magic_acc = magic_acc | (32'(b) << (8 * p));
            if (!stopped) scan_record_byte(b, p, len);
            if (p + 1 < len) begin
                byte_pos = p + 1;
                return;
            end
            mok = (magic_acc == magic_word);
            r.blob_version  = (mok && found) ? version_acc : 32'd0;
            r.version_found = mok && found;
            r.magic_ok      = mok;
            predicted_results.push_back(r);
            clear_scan();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(t_blob_result got);
            t_blob_result want;
            if (predicted_results.size() == 0) begin
                report($sformatf("result with nothing pending, version %h", got.blob_version));
                return;
            end
            want = predicted_results.pop_front();
            if (got.blob_version !== want.blob_version)
                report($sformatf("blob_version %h, predicted %h",
                                 got.blob_version, want.blob_version));
            if (got.version_found !== want.version_found)
                report($sformatf("version_found %b, predicted %b",
                                 got.version_found, want.version_found));
            if (got.magic_ok !== want.magic_ok)
                report($sformatf("magic_ok %b, predicted %b", got.magic_ok, want.magic_ok));
        endtask

        function int pending();
            return predicted_results.size();
        endfunction
    endclass

endpackage

FILE: dv/header_tlv_version_parser_test.sv
// Testbench for header_tlv_version_parser: directed and random headers with
// random gaps and stalls, results checked by the version scoreboard.
// Depends on htvp_pkg, htvp_in_if, htvp_out_if and htvp_version_sb_pkg.
module header_tlv_version_parser_test;
    import htvp_pkg::*;
    import htvp_version_sb_pkg::*;

    localparam int CYCLE_LIMIT = 800_000;
    localparam int FIRST_HOLD  = 300;
    localparam int TOTAL_BYTES = 1400;
    localparam int MIN_HEADERS = 50;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    htvp_in_if  in_if ();
    htvp_out_if out_if ();

    header_tlv_version_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    version_scoreboard sb = new();
    logic [7:0]        hdr_bytes[$];
    bit                burst;
    int                bytes_sent;
    int                headers_sent;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task write_all(input logic [31:0] m, input logic [7:0] pad, input logic [15:0] vt,
                   input int st, input int hl);
        write_reg(CFG_MAGIC_WORD, m);
        write_reg(CFG_PADDING_BYTE, 32'(pad));
        write_reg(CFG_VERSION_TAG, 32'(vt));
        write_reg(CFG_START_OFFSET, 32'(st));
        write_reg(CFG_HEADER_LEN, 32'(hl));
    endtask

    function void put_byte(logic [7:0] b, int lim);
        if (hdr_bytes.size() < lim) hdr_bytes.push_back(b);
    endfunction

    function void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++) hdr_bytes.push_back(w[8*i +: 8]);
    endfunction

    // Mostly well-formed record chains with random content, some noise.
    function void build_header();
        int          lim;
        int          kind;
        int          rlen;
        logic [15:0] tag;
        logic [31:0] mw;
        logic [31:0] val;
        lim = sb.header_bytes();
        hdr_bytes.delete();
        mw = ($urandom_range(0, 7) == 0) ? $urandom() : sb.magic_word;
        for (int i = 0; i < MAGIC_BYTES; i++) put_byte(mw[8*i +: 8], lim);
        while (hdr_bytes.size() < sb.start_offset && hdr_bytes.size() < lim)
            put_byte(8'($urandom_range(0, 255)), lim);
        while (hdr_bytes.size() < lim) begin
            if (hdr_bytes.size() % 2 != 0 || $urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 2) == 0) put_byte(8'($urandom_range(0, 255)), lim);
                else put_byte(sb.padding_byte, lim);
            end else begin
                kind = $urandom_range(0, 9);
                rlen = $urandom_range(0, 10);
                tag  = 16'($urandom_range(1, 65534));
                val  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
                if (kind <= 2) begin
                    if (tag == sb.version_tag) tag = tag ^ 16'h0100;
                end else if (kind == 3) begin
                    tag = sb.version_tag;
                    if (rlen == 4) rlen = 5;
                end else if (kind <= 6) begin
                    tag  = sb.version_tag;
                    rlen = 4;
                end else if (kind == 7) begin
                    tag = $urandom_range(0, 1) ? TAG_END : TAG_NONE;
                end else if (kind == 8) begin
                    // exact fit or just past the header end
                    rlen = lim - hdr_bytes.size() - RECORD_HDR + $urandom_range(0, 2);
                    if (rlen < 0) rlen = 0;
                end else begin
                    rlen = $urandom_range(0, 65535);
                end
                put_byte(tag[7:0], lim);
                put_byte(tag[15:8], lim);
                put_byte(rlen[7:0], lim);
                put_byte(rlen[15:8], lim);
                for (int i = 0; i < rlen && hdr_bytes.size() < lim; i++) begin
                    put_byte(val[7:0], lim);
                    val = {8'($urandom_range(0, 255)), val[31:8]};
                end
            end
        end
    endfunction

    task send_byte(input logic [7:0] b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.header_byte <= b;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        sb.take_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task send_header();
        foreach (hdr_bytes[i]) send_byte(hdr_bytes[i]);
        headers_sent++;
    endtask

    task wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task pick_config(input int ph);
        logic [31:0] m;
        logic [7:0]  pad;
        logic [15:0] vt;
        int          hl;
        int          st;
        hl = $urandom_range(8, 48);
        case ($urandom_range(0, 5))
            0:       st = $urandom_range(0, 3);
            1:       st = $urandom_range(hl - 4, hl + 2);
            default: st = $urandom_range(4, 12);
        endcase
        case ($urandom_range(0, 3))
            0:       m = '0;
            1:       m = '1;
            default: m = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0:       pad = 8'h00;
            1:       pad = 8'hFF;
            default: pad = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0:       vt = 16'd1;
            1:       vt = 16'd65534;
            default: vt = 16'($urandom_range(1, 65534));
        endcase
        case (ph)
            0: begin
                hl = 200;   // one longer header
                st = 8;
            end
            1: begin
                hl = 0;     // clamped to the smallest header
                st = 4;
            end
            2: st = 4096;
            3: begin
                m   = '1;
                pad = 8'h00;
                vt  = 16'd65534;
                hl  = 8;
                st  = 4;
            end
            4: begin
                m   = '0;
                pad = 8'hFF;
                vt  = 16'd1;
            end
            default: ;
        endcase
        write_all(m, pad, vt, st, hl);
    endtask

    initial begin
        int n;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.header_byte = '0;
        bytes_sent        = 0;
        headers_sent      = 0;
        burst             = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // version record right at the start offset, then bad magic with padding
        // and a record that runs past the end
        write_all(RST_MAGIC_WORD, 8'hFF, 16'd1, 4, 12);
        hdr_bytes.delete();
        put_word(RST_MAGIC_WORD);
        put_word(32'h0004_0001);
        put_word(32'hDEAD_BEEF);
        send_header();
        hdr_bytes.delete();
        put_word(RST_MAGIC_WORD ^ 32'h8000_0000);
        put_word(32'h0001_FFFF);
        put_word(32'h0000_0004);
        send_header();
        wait_idle();

        for (int ph = 0; bytes_sent < TOTAL_BYTES || headers_sent < MIN_HEADERS; ph++) begin
            pick_config(ph);
            n = (sb.header_bytes() > 64) ? 1 : $urandom_range(2, 6);
            repeat (n) begin
                burst = ($urandom_range(0, 3) == 0);
                build_header();
                send_header();
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("header_tlv_version_parser verification clean");
        end else begin
            $display("header_tlv_version_parser verification failed");
        end
        $finish;
    end

    initial begin
        int           gap;
        int           taken;
        bit           calm;
        t_blob_result got;
        out_if.ready = 1'b0;
        taken        = 0;
        calm         = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) calm = !calm;
            if (taken == 0) gap = FIRST_HOLD;
            else if ($urandom_range(0, 40) == 0) gap = $urandom_range(40, 120);
            else gap = calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            got.blob_version  = out_if.blob_version;
            got.version_found = out_if.version_found;
            got.magic_ok      = out_if.magic_ok;
            sb.check_result(got);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("header_tlv_version_parser verification failed");
        $finish;
    end

endmodule
